### rtl/plarb_pkg.sv
// Shared constants, codes and types of the persistent lock round-robin arbiter.
`timescale 1ns / 1ps
`default_nettype none
package plarb_pkg;

	// Geometry.
	localparam int NUM_NODES = 16;
	localparam int ADDR_BITS = 48;
	localparam int HOLD_BITS = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
	localparam int NODE_BITS = 4;
	localparam int IDX_W     = (HOLD_BITS > NODE_BITS) ? HOLD_BITS : NODE_BITS;
	localparam int PORT_ADDR = 48;
	localparam int WIDE_ADDR = (ADDR_BITS > PORT_ADDR) ? ADDR_BITS : PORT_ADDR;

	// Stream payload widths.
	localparam int CMD_BITS = 3;
	localparam int ERR_BITS = 2;
	localparam int IN_W     = 56;
	localparam int OUT_W    = 64;

	// Command codes.
	localparam logic [CMD_BITS-1:0] CMD_ADD     = 3'd0;
	localparam logic [CMD_BITS-1:0] CMD_REMOVE  = 3'd1;
	localparam logic [CMD_BITS-1:0] CMD_ADVANCE = 3'd2;
	localparam logic [CMD_BITS-1:0] CMD_ISSUE   = 3'd3;
	localparam logic [CMD_BITS-1:0] CMD_QUERY   = 3'd4;

	// Error codes.
	localparam logic [ERR_BITS-1:0] ERR_NONE    = 2'd0;
	localparam logic [ERR_BITS-1:0] ERR_ADD     = 2'd1;
	localparam logic [ERR_BITS-1:0] ERR_REMOVE  = 2'd2;
	localparam logic [ERR_BITS-1:0] ERR_ADVANCE = 2'd3;

	// Broadcast from the control to every cell.
	typedef struct packed {
		logic                 add_en;
		logic                 rm_en;
		logic [IDX_W-1:0]     node;
		logic [IDX_W-1:0]     holder;
		logic [ADDR_BITS-1:0] addr;
	} cell_ctl_t;

	// Carried from each cell to its upper neighbor.
	typedef struct packed {
		logic                 above_found;
		logic [IDX_W-1:0]     above_idx;
		logic                 low_found;
		logic [IDX_W-1:0]     low_idx;
		logic                 any_valid;
		logic                 any_rest;
		logic                 node_valid;
		logic                 succ;
		logic [ADDR_BITS-1:0] hold_addr;
	} chain_t;

	// Port address into the internal address width.
	function automatic logic [ADDR_BITS-1:0] to_int_addr(input logic [PORT_ADDR-1:0] a);
		logic [WIDE_ADDR-1:0] w;
		w = WIDE_ADDR'(a);
		return w[ADDR_BITS-1:0];
	endfunction

	// Internal address onto the port address width.
	function automatic logic [PORT_ADDR-1:0] to_port_addr(input logic [ADDR_BITS-1:0] a);
		logic [WIDE_ADDR-1:0] w;
		w = WIDE_ADDR'(a);
		return w[PORT_ADDR-1:0];
	endfunction

endpackage
`default_nettype wire

### rtl/plarb_cell.sv
// One per-node cell: holds the entry and extends the neighbor chain.
`timescale 1ns / 1ps
`default_nettype none
module plarb_cell (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [plarb_pkg::IDX_W-1:0] idx,
	input  wire plarb_pkg::cell_ctl_t        ctl,
	input  wire plarb_pkg::chain_t           ci,
	output plarb_pkg::chain_t                co
);

	logic                            valid_q;
	logic [plarb_pkg::ADDR_BITS-1:0] addr_q;
	logic                            sel;
	logic                            above;

	assign sel   = (ctl.node == idx);
	assign above = valid_q && (idx > ctl.holder);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.add_en && sel) begin
			valid_q <= 1'b1;
		end else if (ctl.rm_en && sel) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.add_en && sel) begin
			addr_q <= ctl.addr;
		end
	end

	always_comb begin
		co = ci;
		// First valid entry above the holder, counted from the bottom of the row.
		if (above && !ci.above_found) begin
			co.above_found = 1'b1;
			co.above_idx   = idx;
		end
		// Lowest valid entry, used when the search wraps.
		if (valid_q && !ci.low_found) begin
			co.low_found = 1'b1;
			co.low_idx   = idx;
		end
		co.any_valid  = ci.any_valid | valid_q;
		co.any_rest   = ci.any_rest | (valid_q && !sel);
		co.node_valid = ci.node_valid | (valid_q && sel);
		co.succ       = ci.succ | (valid_q && (idx > ctl.node) && (addr_q == ctl.addr));
		if (idx == ctl.holder) begin
			co.hold_addr = addr_q;
		end
	end

endmodule
`default_nettype wire

### rtl/persistent_lock_round_robin_arbiter.sv
// An accepted item goes through capture, execute and evaluate through the cell row before its
// result shows at m_tdata; a new item is taken only after the last one has left evaluate.
// The input side is free again as soon as the evaluate step has run, even while the
// result still waits in the output register for m_tready.
// Reset (arst_n low, asynchronous): all entries invalid, holder at the last node,
// busy clear, issued address zero, no result pending.
`timescale 1ns / 1ps
`default_nettype none
module persistent_lock_round_robin_arbiter (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// cmd[2:0], node_id[6:3], address[54:7], zero[55]
	input  wire logic [plarb_pkg::IN_W-1:0]  s_tdata,
	// access_type[0]
	input  wire logic                        s_tuser,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// busy_res[0], active_node[4:1], active_address[52:5], any_valid[53],
	// successor_present[54], issued_match[55], error[57:56], zero[63:58]
	output logic [plarb_pkg::OUT_W-1:0]      m_tdata
);

	// The item walks through three steps. In IDLE the block takes an item into the
	// item register. In EXEC the cell row is evaluated on the current entries and the
	// command is applied: cells are written, the holder moves, the issued address is
	// recorded. In EVAL the row is evaluated again on the updated entries and the
	// result is loaded into the output register; the item waits in EVAL while the previous result
	// has not been taken yet.
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_EXEC = 2'd1;
	localparam logic [1:0] PH_EVAL = 2'd2;

	logic [1:0]                             phase_q;
	logic [plarb_pkg::CMD_BITS-1:0]         cmd_q;
	logic [plarb_pkg::IDX_W-1:0]            node_q;
	logic [plarb_pkg::ADDR_BITS-1:0]        addr_q;
	logic [plarb_pkg::IDX_W-1:0]            holder_q;
	logic                                   busy_q;
	logic [plarb_pkg::ADDR_BITS-1:0]        issued_q;
	logic [plarb_pkg::ERR_BITS-1:0]         err_q;
	logic                                   out_valid_q;
	logic [plarb_pkg::OUT_W-1:0]            out_data_q;

	plarb_pkg::cell_ctl_t                   ctl;
	plarb_pkg::chain_t                      chain [plarb_pkg::NUM_NODES+1];
	plarb_pkg::chain_t                      row;
	logic                                   accept;
	logic                                   out_free;
	logic                                   node_ok;
	logic [plarb_pkg::ERR_BITS-1:0]         err_d;
	logic                                   add_go;
	logic                                   rm_go;
	logic [plarb_pkg::OUT_W-1:0]            out_d;
	logic [plarb_pkg::PORT_ADDR-1:0]        act_addr;

	assign s_tready = (phase_q == PH_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Nodes past the end of the row are accepted but their add and remove do nothing.
	assign node_ok = ({1'b0, node_q} < (plarb_pkg::IDX_W+1)'(plarb_pkg::NUM_NODES));

	// Decode of the command against the current entries, used in EXEC.
	always_comb begin
		err_d  = plarb_pkg::ERR_NONE;
		add_go = 1'b0;
		rm_go  = 1'b0;
		case (cmd_q)
			plarb_pkg::CMD_ADD: begin
				if (node_ok) begin
					if (row.node_valid) begin
						err_d = plarb_pkg::ERR_ADD;
					end else begin
						add_go = 1'b1;
					end
				end
			end
			plarb_pkg::CMD_REMOVE: begin
				if (node_ok) begin
					if (!row.node_valid) begin
						err_d = plarb_pkg::ERR_REMOVE;
					end else begin
						rm_go = 1'b1;
					end
				end
			end
			plarb_pkg::CMD_ADVANCE: begin
				if (!row.low_found) begin
					err_d = plarb_pkg::ERR_ADVANCE;
				end
			end
			default: begin
				err_d = plarb_pkg::ERR_NONE;
			end
		endcase
	end

	always_comb begin
		ctl.add_en = (phase_q == PH_EXEC) && add_go;
		ctl.rm_en  = (phase_q == PH_EXEC) && rm_go;
		ctl.node   = node_q;
		ctl.holder = holder_q;
		ctl.addr   = addr_q;
	end

	// The row of cells, node 0 at the bottom; each cell hands its chain to the next.
	assign chain[0] = '0;

	for (genvar i = 0; i < plarb_pkg::NUM_NODES; i++) begin : g_cell
		plarb_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (plarb_pkg::IDX_W'(i)),
			.ctl    (ctl),
			.ci     (chain[i]),
			.co     (chain[i+1])
		);
	end

	assign row = chain[plarb_pkg::NUM_NODES];

	// The stored address of the holder is only shown while busy; busy means the
	// holder's entry has been written at some point.
	assign act_addr = busy_q ? plarb_pkg::to_port_addr(row.hold_addr) : '0;

	always_comb begin
		out_d        = '0;
		out_d[0]     = busy_q;
		out_d[4:1]   = holder_q[3:0];
		out_d[52:5]  = act_addr;
		out_d[53]    = row.any_valid;
		out_d[54]    = row.succ;
		out_d[55]    = (addr_q == issued_q);
		out_d[57:56] = err_q;
	end

	// Item register.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= s_tdata[2:0];
			node_q <= plarb_pkg::IDX_W'(s_tdata[6:3]);
			addr_q <= plarb_pkg::to_int_addr(s_tdata[54:7]);
		end
	end

	// The access type is accepted with the item; no result field depends on it,
	// so it is not kept in the cells.
	logic unused_kind;
	assign unused_kind = s_tuser;

	always_ff @(posedge clk) begin
		if (phase_q == PH_EXEC) begin
			err_q <= err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			holder_q    <= plarb_pkg::IDX_W'(plarb_pkg::NUM_NODES - 1);
			busy_q      <= 1'b0;
			issued_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && !((phase_q == PH_EVAL) && out_free)) begin
				out_valid_q <= 1'b0;
			end
			case (phase_q)
				PH_IDLE: begin
					if (accept) begin
						phase_q <= PH_EXEC;
					end
				end
				PH_EXEC: begin
					phase_q <= PH_EVAL;
					if (rm_go && !row.any_rest) begin
						busy_q <= 1'b0;
					end
					if (cmd_q == plarb_pkg::CMD_ADVANCE) begin
						// Round robin: next valid above the holder, else wrap to lowest.
						if (row.above_found) begin
							holder_q <= row.above_idx;
							busy_q   <= 1'b1;
						end else if (row.low_found) begin
							holder_q <= row.low_idx;
							busy_q   <= 1'b1;
						end
					end
					if (cmd_q == plarb_pkg::CMD_ISSUE) begin
						issued_q <= addr_q;
					end
				end
				PH_EVAL: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						phase_q     <= PH_IDLE;
					end
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((phase_q == PH_EVAL) && out_free) begin
			out_data_q <= out_d;
		end
	end

endmodule
`default_nettype wire

### rtl/plarb_checker.sv
// Port-level checks of the persistent lock arbiter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module plarb_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       s_tvalid,
	input wire logic                       s_tready,
	input wire logic                       m_tvalid,
	input wire logic                       m_tready,
	input wire logic [plarb_pkg::OUT_W-1:0] m_tdata
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// One item at a time: the input closes right after an item is taken.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input open directly after an accepted item");

	// A failed advance means the table is empty.
	a_adv_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[57:56] == plarb_pkg::ERR_ADVANCE) |-> !m_tdata[53])
		else $error("advance failed with valid entries present");

	// Busy never outlives the last entry.
	a_busy_entry: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[53])
		else $error("busy with no valid entry");

	// Without a holder the reported address is zero.
	a_idle_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[52:5] == '0))
		else $error("address reported while not busy");

endmodule

bind persistent_lock_round_robin_arbiter plarb_checker u_plarb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
